@@ hw/rtl/oeq_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the ordered event queue.
package oeq_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int MAX_RES   = 32;
	localparam int KW        = $clog2(MAX_RES + 1);

	localparam logic [1:0] CMD_PUBLISH = 2'd0;
	localparam logic [1:0] CMD_DRAIN   = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic [2:0] STS_PUBLISHED = 3'd0;
	localparam logic [2:0] STS_DELIVERED = 3'd1;
	localparam logic [2:0] STS_NONE_DUE  = 3'd2;
	localparam logic [2:0] STS_FULL      = 3'd3;
	localparam logic [2:0] STS_CLEARED   = 3'd4;

	localparam logic [5:0] PEND_MAX = 6'd63;

	typedef struct packed {
		logic        [31:0] tick;
		logic signed [15:0] lane;
		logic        [31:0] seq;
		logic        [15:0] topic;
		logic        [31:0] payload;
	} slot_t;

	typedef struct packed {
		logic        live;
		logic        has_best;
		logic [31:0] limit;
	} cmp_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SINGLE,
		S_SCAN,
		S_FOUND,
		S_LAST
	} state_t;

endpackage

@@ hw/rtl/oeq_slot_mem.sv @@
`timescale 1ns / 1ps
// Event slot storage: one write port, one registered read port.
module oeq_slot_mem #(
	parameter int DEPTH = oeq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  oeq_pkg::slot_t             wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output oeq_pkg::slot_t             rdata
);
	import oeq_pkg::*;

	slot_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/oeq_order_cmp.sv @@
`timescale 1ns / 1ps
// Shared ordering compare: is the candidate due and served before the best so far.
module oeq_order_cmp (
	input  oeq_pkg::slot_t    cand,
	input  oeq_pkg::slot_t    best,
	input  oeq_pkg::cmp_ctl_t ctl,
	output logic              take
);
	import oeq_pkg::*;

	logic due;
	logic earlier;

	always_comb begin
		due = ctl.live && (cand.tick <= ctl.limit);
		if (cand.tick != best.tick) begin
			earlier = cand.tick < best.tick;
		end else if (cand.lane != best.lane) begin
			earlier = cand.lane < best.lane;
		end else begin
			earlier = cand.seq < best.seq;
		end
		take = due && (!ctl.has_best || earlier);
	end

endmodule

@@ hw/rtl/ordered_event_queue_unit.sv @@
`timescale 1ns / 1ps
// Top level of the ordered event queue: sequencer, slot state and result register.
//
//  channel | handshake            | words
//  --------+----------------------+----------------------------------------------------
//  req     | req_valid/req_ready  | cmd, tick, lane, topic_tag, payload_tag
//  rsp     | rsp_valid/rsp_ready  | status, seq_number, event_*, pending, last
//
// Publish and clear pass through S_SINGLE to a result. A drain scans every slot through
// one compare unit for each delivered word, plus a final scan that finds none due
// (no final scan once MAX_RES words are out).
// req_ready is high only while the sequencer is idle; one request is worked at a time.
// A held result word lets the next request in while it waits; a stalled rsp holds the scan.
// Reset clears the slot valid bits, the count and the sequence counter at once.
module ordered_event_queue_unit #(
	parameter int DEPTH = oeq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         cmd,
	input  logic [31:0]        tick,
	input  logic signed [15:0] lane,
	input  logic [15:0]        topic_tag,
	input  logic [31:0]        payload_tag,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [2:0]         status,
	output logic [31:0]        seq_number,
	output logic [31:0]        event_tick,
	output logic signed [15:0] event_lane,
	output logic [15:0]        event_topic,
	output logic [31:0]        event_payload,
	output logic [5:0]         pending,
	output logic               last
);
	import oeq_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [1:0]         cmd_q;
	logic [31:0]        tick_q;
	logic signed [15:0] lane_q;
	logic [15:0]        topic_q;
	logic [31:0]        payload_q;

	logic [DEPTH-1:0] valid_q;
	logic [CW-1:0]    count_q;
	logic [31:0]      next_seq_q;

	logic [IW:0]   scan_q;
	logic          chk_v_q;
	logic [IW-1:0] chk_idx_q;
	slot_t         best_q;
	logic [IW-1:0] best_idx_q;
	logic          have_best_q;

	slot_t         held_q;
	logic [5:0]    held_pend_q;
	logic          held_v_q;
	logic [KW-1:0] k_q;

	logic          rsp_valid_q;
	logic [2:0]    status_q;
	slot_t         out_q;
	logic [5:0]    pend_q;
	logic          last_q;

	logic          accept;
	logic          out_free;
	logic          full;
	logic [IW-1:0] free_idx;
	logic          scan_issue;
	slot_t         rd_data;
	slot_t         wr_data;
	cmp_ctl_t      cmp_ctl;
	logic          take;

	logic          ld;
	logic [2:0]    res_status;
	slot_t         res_word;
	logic [5:0]    res_pend;
	logic          res_last;
	logic          pub_go;
	logic          clr_go;
	logic          take_go;
	logic          scan_go;

	function automatic logic [5:0] pend_of(input logic [CW-1:0] n);
		return (32'(n) > 32'(PEND_MAX)) ? PEND_MAX : 6'(n);
	endfunction

	assign req_ready  = (state_q == S_IDLE);
	assign accept     = req_valid && req_ready;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign full       = (count_q == CW'(DEPTH));
	assign scan_issue = (scan_q < (IW + 1)'(DEPTH));

	always_comb begin
		free_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
			end
		end
	end

	always_comb begin
		wr_data         = '0;
		wr_data.tick    = tick_q;
		wr_data.lane    = lane_q;
		wr_data.seq     = next_seq_q;
		wr_data.topic   = topic_q;
		wr_data.payload = payload_q;
	end

	oeq_slot_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (pub_go),
		.waddr(free_idx),
		.wdata(wr_data),
		.raddr(scan_q[IW-1:0]),
		.rdata(rd_data)
	);

	assign cmp_ctl.live     = chk_v_q && valid_q[chk_idx_q];
	assign cmp_ctl.has_best = have_best_q;
	assign cmp_ctl.limit    = tick_q;

	oeq_order_cmp u_cmp (
		.cand(rd_data),
		.best(best_q),
		.ctl (cmp_ctl),
		.take(take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ld         = 1'b0;
		res_status = STS_PUBLISHED;
		res_word   = '0;
		res_pend   = '0;
		res_last   = 1'b0;
		pub_go     = 1'b0;
		clr_go     = 1'b0;
		take_go    = 1'b0;
		scan_go    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (cmd) inside
						CMD_PUBLISH, CMD_CLEAR: begin
							state_d = S_SINGLE;
						end
						CMD_DRAIN: begin
							state_d = S_SCAN;
							scan_go = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_SINGLE: begin
				if (out_free) begin
					ld       = 1'b1;
					res_last = 1'b1;
					state_d  = S_IDLE;
					if (cmd_q == CMD_CLEAR) begin
						clr_go     = 1'b1;
						res_status = STS_CLEARED;
					end else if (full) begin
						res_status = STS_FULL;
						res_pend   = pend_of(count_q);
					end else begin
						pub_go       = 1'b1;
						res_status   = STS_PUBLISHED;
						res_word.seq = next_seq_q;
						res_pend     = pend_of(CW'(count_q + 1'b1));
					end
				end
			end
			S_SCAN: begin
				if (chk_v_q && chk_idx_q == IW'(DEPTH - 1)) begin
					state_d = S_FOUND;
				end
			end
			S_FOUND: begin
				if (have_best_q) begin
					if (!held_v_q || out_free) begin
						take_go = 1'b1;
						if (held_v_q) begin
							ld         = 1'b1;
							res_status = STS_DELIVERED;
							res_word   = held_q;
							res_pend   = held_pend_q;
						end
						if (k_q == KW'(MAX_RES - 1)) begin
							state_d = S_LAST;
						end else begin
							state_d = S_SCAN;
							scan_go = 1'b1;
						end
					end
				end else if (out_free) begin
					ld       = 1'b1;
					res_last = 1'b1;
					state_d  = S_IDLE;
					if (held_v_q) begin
						res_status = STS_DELIVERED;
						res_word   = held_q;
						res_pend   = held_pend_q;
					end else begin
						res_status = STS_NONE_DUE;
						res_pend   = pend_of(count_q);
					end
				end
			end
			S_LAST: begin
				if (out_free) begin
					ld         = 1'b1;
					res_last   = 1'b1;
					res_status = STS_DELIVERED;
					res_word   = held_q;
					res_pend   = held_pend_q;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			tick_q    <= tick;
			lane_q    <= lane;
			topic_q   <= topic_tag;
			payload_q <= payload_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			count_q    <= '0;
			next_seq_q <= '0;
		end else if (clr_go) begin
			valid_q    <= '0;
			count_q    <= '0;
			next_seq_q <= '0;
		end else if (pub_go) begin
			valid_q[free_idx] <= 1'b1;
			count_q           <= CW'(count_q + 1'b1);
			next_seq_q        <= next_seq_q + 32'd1;
		end else if (take_go) begin
			valid_q[best_idx_q] <= 1'b0;
			count_q             <= CW'(count_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			chk_v_q     <= 1'b0;
			have_best_q <= 1'b0;
		end else if (scan_go) begin
			scan_q      <= '0;
			chk_v_q     <= 1'b0;
			have_best_q <= 1'b0;
		end else if (state_q == S_SCAN) begin
			if (scan_issue) begin
				scan_q <= scan_q + 1'b1;
			end
			chk_v_q <= scan_issue;
			if (take) begin
				have_best_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			chk_idx_q <= scan_q[IW-1:0];
			if (take) begin
				best_q     <= rd_data;
				best_idx_q <= chk_idx_q;
			end
		end
		if (take_go) begin
			held_q      <= best_q;
			held_pend_q <= pend_of(CW'(count_q - 1'b1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			k_q      <= '0;
		end else if (accept) begin
			held_v_q <= 1'b0;
			k_q      <= '0;
		end else if (take_go) begin
			held_v_q <= 1'b1;
			k_q      <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			status_q <= res_status;
			out_q    <= res_word;
			pend_q   <= res_pend;
			last_q   <= res_last;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign seq_number    = out_q.seq;
	assign event_tick    = out_q.tick;
	assign event_lane    = out_q.lane;
	assign event_topic   = out_q.topic;
	assign event_payload = out_q.payload;
	assign pending       = pend_q;
	assign last          = last_q;

endmodule

@@ verif/tb_ordered_event_queue_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the ordered event queue: sorted publish, drain, clear, reject.
module tb_ordered_event_queue_unit;
	import oeq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 4 * (DEPTH + 2);

	typedef struct {
		logic [1:0]         cmd;
		logic [31:0]        tick;
		logic signed [15:0] lane;
		logic [15:0]        topic;
		logic [31:0]        payload;
	} req_word_t;

	typedef struct {
		logic [2:0]         status;
		logic [31:0]        seq;
		logic [31:0]        tick;
		logic signed [15:0] lane;
		logic [15:0]        topic;
		logic [31:0]        payload;
		logic [5:0]         pending;
		logic               last;
	} reply_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic [1:0]         cmd;
	logic [31:0]        tick;
	logic signed [15:0] lane;
	logic [15:0]        topic_tag;
	logic [31:0]        payload_tag;
	logic               rsp_valid;
	logic               rsp_ready;
	logic [2:0]         status;
	logic [31:0]        seq_number;
	logic [31:0]        event_tick;
	logic signed [15:0] event_lane;
	logic [15:0]        event_topic;
	logic [31:0]        event_payload;
	logic [5:0]         pending;
	logic               last;

	ordered_event_queue_unit #(.DEPTH(DEPTH)) dut (.*);

	req_word_t request_q[$];
	reply_t    reply_q[$];
	int        sent_count;
	int        taken_count;
	int        err_count;
	int        quiet_cycles;
	int        send_idle;
	int        recv_idle;
	logic [31:0] tick_base;

	bit [31:0]        ev_tick[DEPTH];
	bit signed [15:0] ev_lane[DEPTH];
	bit [31:0]        ev_seq[DEPTH];
	bit [15:0]        ev_topic[DEPTH];
	bit [31:0]        ev_payload[DEPTH];
	bit               ev_live[DEPTH];
	int               live_count;
	bit [31:0]        seq_counter;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic bit serves_first(int a, int b);
		if (ev_tick[a] != ev_tick[b])
			return ev_tick[a] < ev_tick[b];
		if (ev_lane[a] != ev_lane[b])
			return ev_lane[a] < ev_lane[b];
		return ev_seq[a] < ev_seq[b];
	endfunction

	function automatic logic [5:0] pend_sat(int n);
		return (n > int'(PEND_MAX)) ? PEND_MAX : 6'(n);
	endfunction

	function automatic void apply_request(req_word_t w);
		int slot;
		int best;
		int n;
		reply_t r;
		r = '{default: '0};
		r.last = 1'b1;
		case (w.cmd)
		CMD_PUBLISH: begin
			slot = -1;
			for (int i = 0; i < DEPTH; i++)
				if (!ev_live[i] && slot < 0)
					slot = i;
			if (slot < 0) begin
				r.status = STS_FULL;
			end else begin
				ev_tick[slot]    = w.tick;
				ev_lane[slot]    = w.lane;
				ev_seq[slot]     = seq_counter;
				ev_topic[slot]   = w.topic;
				ev_payload[slot] = w.payload;
				ev_live[slot]    = 1'b1;
				live_count++;
				r.status = STS_PUBLISHED;
				r.seq = seq_counter;
				seq_counter++;
			end
			r.pending = pend_sat(live_count);
			reply_q.insert(reply_q.size(), r);
		end
		CMD_DRAIN: begin
			n = 0;
			while (n < MAX_RES) begin
				best = -1;
				for (int i = 0; i < DEPTH; i++)
					if (ev_live[i] && ev_tick[i] <= w.tick)
						if (best < 0 || serves_first(i, best))
							best = i;
				if (best < 0)
					break;
				ev_live[best] = 1'b0;
				live_count--;
				r.status  = STS_DELIVERED;
				r.seq     = ev_seq[best];
				r.tick    = ev_tick[best];
				r.lane    = ev_lane[best];
				r.topic   = ev_topic[best];
				r.payload = ev_payload[best];
				r.pending = pend_sat(live_count);
				r.last    = 1'b0;
				reply_q.insert(reply_q.size(), r);
				n++;
			end
			if (n == 0) begin
				r.status = STS_NONE_DUE;
				r.pending = pend_sat(live_count);
				reply_q.insert(reply_q.size(), r);
			end else begin
				reply_q[reply_q.size() - 1].last = 1'b1;
			end
		end
		CMD_CLEAR: begin
			for (int i = 0; i < DEPTH; i++)
				ev_live[i] = 1'b0;
			live_count = 0;
			seq_counter = '0;
			r.status = STS_CLEARED;
			reply_q.insert(reply_q.size(), r);
		end
		default: begin
		end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		reply_t want;
		req_word_t w;
		if (arst_n) begin
			quiet_cycles++;
			if (req_valid && req_ready) begin
				w.cmd = cmd;
				w.tick = tick;
				w.lane = lane;
				w.topic = topic_tag;
				w.payload = payload_tag;
				apply_request(w);
				taken_count++;
				quiet_cycles = 0;
			end
			if (rsp_valid && rsp_ready) begin
				quiet_cycles = 0;
				if (reply_q.size() == 0) begin
					$error("result word with none expected, status %0d", status);
					err_count++;
				end else begin
					want = reply_q.pop_front();
					check_field("status", want.status, status);
					check_field("seq_number", want.seq, seq_number);
					check_field("event_tick", want.tick, event_tick);
					check_field("event_lane", want.lane, event_lane);
					check_field("event_topic", want.topic, event_topic);
					check_field("event_payload", want.payload, event_payload);
					check_field("pending", want.pending, pending);
					check_field("last", want.last, last);
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	always @(negedge clk) begin : driver
		req_word_t w;
		if (arst_n) begin
			if (!(req_valid && sent_count != taken_count)) begin
				if (request_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					w = request_q.pop_front();
					cmd <= w.cmd;
					tick <= w.tick;
					lane <= w.lane;
					topic_tag <= w.topic;
					payload_tag <= w.payload;
					req_valid <= 1'b1;
					sent_count++;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	function automatic void push_word(logic [1:0] c, logic [31:0] t, logic signed [15:0] l,
			logic [15:0] tp, logic [31:0] pl);
		req_word_t w;
		w.cmd = c;
		w.tick = t;
		w.lane = l;
		w.topic = tp;
		w.payload = pl;
		request_q.insert(request_q.size(), w);
	endfunction

	function automatic void push_publish();
		logic [31:0]        t;
		logic signed [15:0] l;
		t = ($urandom_range(0, 5) == 0) ? $urandom() : tick_base + $urandom_range(0, 12);
		l = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4)) - 16'sd2;
		push_word(CMD_PUBLISH, t, l, 16'($urandom()), $urandom());
	endfunction

	task automatic push_random(int n);
		int added;
		int r;
		int burst;
		logic [31:0] lim;
		added = 0;
		while (added < n) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				burst = $urandom_range(1, 6);
				repeat (burst)
					push_publish();
				added += burst;
			end else if (r < 82) begin
				lim = ($urandom_range(0, 7) == 0) ? $urandom()
					: tick_base + $urandom_range(0, 10);
				push_word(CMD_DRAIN, lim, 16'($urandom()), 16'($urandom()), $urandom());
				tick_base += $urandom_range(0, 6);
				added++;
			end else if (r < 88) begin
				push_word(CMD_DRAIN, 32'hFFFF_FFFF, 16'($urandom()), 16'($urandom()),
					$urandom());
				added++;
			end else if (r < 94) begin
				push_word(CMD_CLEAR, $urandom(), 16'($urandom()), 16'($urandom()), $urandom());
				added++;
			end else begin
				push_word(CMD_UNKNOWN, $urandom(), 16'($urandom()), 16'($urandom()),
					$urandom());
			end
		end
	endtask

	task automatic settle();
		while (request_q.size() != 0 || sent_count != taken_count || reply_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		cmd = CMD_PUBLISH;
		tick = '0;
		lane = '0;
		topic_tag = '0;
		payload_tag = '0;
		rsp_ready = 1'b0;
		sent_count = 0;
		taken_count = 0;
		err_count = 0;
		quiet_cycles = 0;
		live_count = 0;
		seq_counter = '0;
		send_idle = 16;
		recv_idle = 53;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_word(CMD_DRAIN, 32'd0, 16'sd0, 16'd0, 32'd0);
		push_word(CMD_PUBLISH, 32'hFFFF_FFFF, 16'sh7FFF, 16'hFFFF, 32'hFFFF_FFFF);
		push_word(CMD_PUBLISH, 32'd0, -16'sh8000, 16'h0000, 32'h0000_0000);
		push_word(CMD_PUBLISH, 32'd7, 16'sd1, 16'h1111, 32'hA5A5_0001);
		push_word(CMD_PUBLISH, 32'd7, -16'sd1, 16'h2222, 32'hA5A5_0002);
		push_word(CMD_PUBLISH, 32'd7, -16'sd1, 16'h3333, 32'hA5A5_0003);
		push_word(CMD_PUBLISH, 32'd7, -16'sh8000, 16'h4444, 32'hA5A5_0004);
		push_word(CMD_UNKNOWN, $urandom(), 16'($urandom()), 16'($urandom()), $urandom());
		push_word(CMD_DRAIN, 32'd6, 16'sd0, 16'd0, 32'd0);
		push_word(CMD_DRAIN, 32'd6, 16'sd0, 16'd0, 32'd0);
		push_word(CMD_DRAIN, 32'd7, 16'sd0, 16'd0, 32'd0);
		push_word(CMD_DRAIN, 32'hFFFF_FFFE, 16'sd0, 16'd0, 32'd0);
		push_word(CMD_DRAIN, 32'hFFFF_FFFF, 16'sd0, 16'd0, 32'd0);
		push_word(CMD_PUBLISH, 32'd3, 16'sd5, 16'h5555, 32'h5555_5555);
		push_word(CMD_CLEAR, 32'd0, 16'sd0, 16'd0, 32'd0);
		push_word(CMD_PUBLISH, 32'd9, 16'sd0, 16'hABCD, 32'h1234_5678);
		push_word(CMD_DRAIN, 32'hFFFF_FFFF, 16'sd0, 16'd0, 32'd0);

		tick_base = $urandom_range(16, 4000);
		push_random(18);
		settle();

		send_idle = 53;
		recv_idle = 16;
		push_word(CMD_CLEAR, 32'd0, 16'sd0, 16'd0, 32'd0);
		repeat (DEPTH + 2)
			push_publish();
		push_word(CMD_DRAIN, 32'hFFFF_FFFF, 16'sd0, 16'd0, 32'd0);
		push_random(16);
		settle();

		send_idle = 0;
		recv_idle = 0;
		push_random(16);
		settle();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && reply_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
